// ===== rtl/nce_pkg.sv =====
// Shared constants, codes and types of the nearest exemplar color classifier.
package nce_pkg;

   localparam int COLOR_W     = 16;
   localparam int DIST_W      = 34;
   localparam int SLOT_W      = 4;
   localparam int COUNT_W     = 5;
   localparam int INDEX_W     = 5;
   localparam int TABLE_SLOTS = 16;
   localparam int CSR_INDEX_W = 1;

   // Result index when nothing lies under the threshold
   localparam logic [INDEX_W-1:0] MATCH_NONE = 5'h1F;

   // Input word kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_COUNT     = 1'b1;

   // Command codes passed from front to back
   localparam logic [1:0] OP_SKIP  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_PIXEL = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [SLOT_W-1:0]  slot;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               window_end;
   } cmd_type;

endpackage

// ===== rtl/nce_channels.sv =====
// Handshake channels for input words and result words.
interface nce_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [nce_pkg::SLOT_W-1:0]  exemplar_slot;
   logic [nce_pkg::COLOR_W-1:0] red;
   logic [nce_pkg::COLOR_W-1:0] green;
   logic [nce_pkg::COLOR_W-1:0] blue;
   logic                        window_end;

   modport source (output valid, kind, exemplar_slot, red, green, blue, window_end,
                   input ready);
   modport sink   (input valid, kind, exemplar_slot, red, green, blue, window_end,
                   output ready);
endinterface

interface nce_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [nce_pkg::INDEX_W-1:0] match_index;
   logic [nce_pkg::DIST_W-1:0]         min_distance;

   modport source (output valid, match_index, min_distance, input ready);
   modport sink   (input valid, match_index, min_distance, output ready);
endinterface

// ===== rtl/nce_front.sv =====
// Front end: accepts input words, masks colors and classifies them into commands.
module nce_front #(
   parameter int TABLE_DEPTH = 16,
   parameter int COLOR_BITS  = 16
) (
   nce_req_if.sink          req_ch,
   input  logic             q_full,
   output logic             q_push,
   output nce_pkg::cmd_type q_cmd
);
   import nce_pkg::*;

   localparam int COLOR_EFF = (COLOR_BITS < COLOR_W) ? COLOR_BITS : COLOR_W;
   localparam logic [COLOR_W-1:0] COLOR_MASK =
      COLOR_W'((COLOR_W+1)'(1) << COLOR_EFF) - COLOR_W'(1);
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);

   logic slot_in_table;

   // Take a word whenever the queue has room
   assign req_ch.ready  = !q_full;
   assign q_push        = req_ch.valid && !q_full;
   assign slot_in_table = {1'b0, req_ch.exemplar_slot} < DEPTH_C;

   // Classify and mask the word
   always_comb begin
      q_cmd.slot       = req_ch.exemplar_slot;
      q_cmd.red        = req_ch.red & COLOR_MASK;
      q_cmd.green      = req_ch.green & COLOR_MASK;
      q_cmd.blue       = req_ch.blue & COLOR_MASK;
      q_cmd.window_end = req_ch.window_end;
      priority if (req_ch.kind == KIND_PIXEL) begin
         q_cmd.op = OP_PIXEL;
      end else if (slot_in_table) begin
         q_cmd.op = OP_LOAD;
      end else begin
         q_cmd.op = OP_SKIP;
      end
   end

endmodule

// ===== rtl/nce_queue.sv =====
// Two-entry command queue between front and back.
module nce_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nce_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output nce_pkg::cmd_type pop_cmd
);
   import nce_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = fill_ff == 2'd2;
   assign not_empty = fill_ff != 2'd0;
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/nce_back.sv =====
// Back end: exemplar table, shared distance pipeline, running minimum and result register.
module nce_back #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_not_empty,
   input  nce_pkg::cmd_type            q_cmd,
   output logic                        q_pop,
   input  logic [nce_pkg::DIST_W-1:0]  threshold,
   input  logic [nce_pkg::COUNT_W-1:0] exemplar_count,
   nce_rsp_if.source                   rsp_ch
);
   import nce_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);
   localparam int ENTRY_W = 3 * COLOR_W;
   localparam int SQ_W = 2 * COLOR_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COLOR_W-1:0] pix_r_ff, pix_g_ff, pix_b_ff;
   logic               wend_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic               s2_valid_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic [SQ_W-1:0]    sq_r_ff, sq_g_ff, sq_b_ff;
   logic [DIST_W-1:0]  best_dist_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;

   logic [COUNT_W-1:0] active_n;
   logic               last_idx;
   logic               drained;
   logic               out_free;
   logic               finish;
   logic               emit;
   logic               start_pixel;
   logic               load_entry;
   logic [COLOR_W-1:0] diff_r, diff_g, diff_b;
   logic [DIST_W-1:0]  dist_sum;

   assign active_n    = (exemplar_count > DEPTH_C) ? DEPTH_C : exemplar_count;
   assign last_idx    = (COUNT_W'(idx_ff) + COUNT_W'(1)) == active_n;
   assign drained     = !s1_valid_ff && !s2_valid_ff;
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign q_pop       = (state_ff == ST_IDLE) && q_not_empty;
   assign start_pixel = q_pop && (q_cmd.op == OP_PIXEL);
   assign load_entry  = q_pop && (q_cmd.op == OP_LOAD);
   assign finish      = (state_ff == ST_DRAIN) && drained && (!wend_ff || out_free);
   assign emit        = finish && wend_ff;

   // Sequence one command at a time
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      s1_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (start_pixel) begin
               state_in = (active_n == '0) ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            s1_valid_in = 1'b1;
            idx_in      = idx_ff + IDX_W'(1);
            if (last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Hold the pixel under work
   always_ff @(posedge clock) begin
      if (start_pixel) begin
         pix_r_ff <= q_cmd.red;
         pix_g_ff <= q_cmd.green;
         pix_b_ff <= q_cmd.blue;
         wend_ff  <= q_cmd.window_end;
      end
   end

   // Exemplar table: write on load, registered read at the scan index
   always_ff @(posedge clock) begin
      if (load_entry) begin
         table_mem[q_cmd.slot[IDX_W-1:0]] <= {q_cmd.red, q_cmd.green, q_cmd.blue};
      end
      rd_data_ff <= table_mem[idx_ff];
      s1_idx_ff  <= idx_ff;
   end

   // Absolute differences and squares
   always_comb begin
      diff_r = (pix_r_ff >= rd_data_ff[3*COLOR_W-1:2*COLOR_W])
             ? pix_r_ff - rd_data_ff[3*COLOR_W-1:2*COLOR_W]
             : rd_data_ff[3*COLOR_W-1:2*COLOR_W] - pix_r_ff;
      diff_g = (pix_g_ff >= rd_data_ff[2*COLOR_W-1:COLOR_W])
             ? pix_g_ff - rd_data_ff[2*COLOR_W-1:COLOR_W]
             : rd_data_ff[2*COLOR_W-1:COLOR_W] - pix_g_ff;
      diff_b = (pix_b_ff >= rd_data_ff[COLOR_W-1:0])
             ? pix_b_ff - rd_data_ff[COLOR_W-1:0]
             : rd_data_ff[COLOR_W-1:0] - pix_b_ff;
   end

   always_ff @(posedge clock) begin
      sq_r_ff   <= SQ_W'(diff_r) * SQ_W'(diff_r);
      sq_g_ff   <= SQ_W'(diff_g) * SQ_W'(diff_g);
      sq_b_ff   <= SQ_W'(diff_b) * SQ_W'(diff_b);
      s2_idx_ff <= s1_idx_ff;
   end

   // Sum of squares never exceeds the distance width for 16-bit colors
   assign dist_sum = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   // Track the running minimum; strictly smaller replaces, restart on emit
   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= '1;
         best_idx_ff  <= '0;
      end else if (emit) begin
         best_dist_ff <= '1;
         best_idx_ff  <= '0;
      end else if (s2_valid_ff && (dist_sum < best_dist_ff)) begin
         best_dist_ff <= dist_sum;
         best_idx_ff  <= s2_idx_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_index_ff <= (best_dist_ff < threshold)
                       ? {1'b0, SLOT_W'(best_idx_ff)} : MATCH_NONE;
         rsp_dist_ff  <= best_dist_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.match_index  = rsp_index_ff;
   assign rsp_ch.min_distance = rsp_dist_ff;

endmodule

// ===== rtl/nearest_color_exemplar_window.sv =====
// Nearest exemplar color classifier over a pixel window: top level with registers.
// A load word writes the table in the back end; a pixel is compared with N exemplars,
// N being the active exemplar count (at most 16), through the one shared distance
// pipeline that reads one table entry per cycle. A window result is registered once its
// last pixel drains and the output is free; a two-word queue lets the input keep flowing.
// Synchronous active-high reset clears registers, queue and result; table is not cleared.
module nearest_color_exemplar_window #(
   parameter int MAX_EXEMPLARS = 16,
   parameter int COLOR_BITS    = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   nce_req_if.sink                         req_ch,
   nce_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [nce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nce_pkg::DIST_W-1:0]      csr_wdata
);
   import nce_pkg::*;

   localparam int TABLE_DEPTH = (MAX_EXEMPLARS < TABLE_SLOTS) ? MAX_EXEMPLARS : TABLE_SLOTS;

   logic [DIST_W-1:0]  threshold_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               q_full, q_push, q_pop, q_not_empty;
   cmd_type            push_cmd, pop_cmd;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         count_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_THRESHOLD: threshold_ff <= csr_wdata;
            REG_COUNT:     count_ff     <= csr_wdata[COUNT_W-1:0];
            default:       threshold_ff <= threshold_ff;
         endcase
      end
   end

   nce_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COLOR_BITS  (COLOR_BITS)
   ) u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   nce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (pop_cmd)
   );

   nce_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_cmd          (pop_cmd),
      .q_pop          (q_pop),
      .threshold      (threshold_ff),
      .exemplar_count (count_ff),
      .rsp_ch         (rsp_ch)
   );

endmodule
